// ===== hw/rtl/jpt_pkg.sv =====
// ----------------------------------------------------------------------------
// jpt_pkg
// Shared types, constants and helper functions for the JSONPath tokenizer.
// ----------------------------------------------------------------------------
package jpt_pkg;

  // Longest decimal index accepted, in digits.
  localparam int unsigned MaxIndexDigits = 10;

  // The digit counter holds up to one past the limit.
  localparam int unsigned DigitCntW = $clog2(MaxIndexDigits + 2);
  localparam logic [DigitCntW-1:0] MaxDigits = DigitCntW'(MaxIndexDigits);

  localparam int unsigned CharW  = 8;
  localparam int unsigned IndexW = 34;

  // Result queue: room for the largest burst of one byte plus one waiting result.
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // Characters with a special meaning in the query text.
  localparam logic [CharW-1:0] ChDollar    = 8'h24;
  localparam logic [CharW-1:0] ChDot       = 8'h2e;
  localparam logic [CharW-1:0] ChLBracket  = 8'h5b;
  localparam logic [CharW-1:0] ChRBracket  = 8'h5d;
  localparam logic [CharW-1:0] ChQuote     = 8'h22;
  localparam logic [CharW-1:0] ChBackslash = 8'h5c;
  localparam logic [CharW-1:0] ChSlash     = 8'h2f;
  localparam logic [CharW-1:0] ChZero      = 8'h30;
  localparam logic [CharW-1:0] ChOne       = 8'h31;
  localparam logic [CharW-1:0] ChNine      = 8'h39;

  // Parser modes.
  typedef enum logic [3:0] {
    MODE_DOLLAR,
    MODE_SEG,
    MODE_DOT_FIRST,
    MODE_DOT_KEY,
    MODE_BR_OPEN,
    MODE_QKEY,
    MODE_QESC,
    MODE_QCLOSE,
    MODE_ZERO_CLOSE,
    MODE_DIGITS,
    MODE_ERR
  } mode_e;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_KEY_BYTE = 2'd0,
    KIND_KEY_END  = 2'd1,
    KIND_INDEX    = 2'd2,
    KIND_FINISHED = 2'd3
  } kind_e;

  // Query completion status.
  typedef enum logic [3:0] {
    ST_OK          = 4'd0,
    ST_NO_DOLLAR   = 4'd1,
    ST_DANGLING    = 4'd2,
    ST_EMPTY_KEY   = 4'd3,
    ST_BAD_ESCAPE  = 4'd4,
    ST_MISSING     = 4'd5,
    ST_INDEX_LONG  = 4'd6,
    ST_BAD_BRACKET = 4'd7,
    ST_UNKNOWN_SEG = 4'd8
  } status_e;

  // One result as held in the output queue.
  typedef struct packed {
    kind_e              kind;
    logic [CharW-1:0]   key_char;
    logic [IndexW-1:0]  index_value;
    status_e            status;
    logic               last_of_run;
  } result_t;

  // ASCII letters and digits only.
  function automatic logic is_alnum(input logic [CharW-1:0] c);
    return ((c >= 8'h30) && (c <= 8'h39)) ||
           ((c >= 8'h41) && (c <= 8'h5a)) ||
           ((c >= 8'h61) && (c <= 8'h7a));
  endfunction

  function automatic logic is_digit(input logic [CharW-1:0] c);
    return (c >= ChZero) && (c <= ChNine);
  endfunction

  // Escape letter decode: bit 8 set when the letter is a known escape.
  function automatic logic [CharW:0] decode_escape(input logic [CharW-1:0] c);
    logic [CharW:0] res;
    res = '0;
    case (c)
      ChBackslash, ChQuote, ChSlash: res = {1'b1, c};
      8'h6e:   res = {1'b1, 8'h0a};
      8'h62:   res = {1'b1, 8'h08};
      8'h72:   res = {1'b1, 8'h0d};
      8'h66:   res = {1'b1, 8'h0c};
      8'h74:   res = {1'b1, 8'h09};
      default: res = '0;
    endcase
    return res;
  endfunction

endpackage

// ===== hw/rtl/json_path_tokenizer_core.sv =====
// ----------------------------------------------------------------------------
// json_path_tokenizer_core
// Byte-serial JSONPath query tokenizer: streams key bytes, key ends, index
// values and a final status for each query.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake               | Payload
//  --------+-------------------------+---------------------------------------
//  in      | in_valid_i / in_ready_o | char_byte_i, end_of_query_i
//  out     | out_valid_o/out_ready_i | event_kind_o, key_char_o, index_value_o,
//          |                         | status_o, last_of_run_o
//
// One byte is accepted per cycle while the queue has room; a byte is held in the input
// register, then its results, none to three, enter a four-entry result queue.
// The queue drains one result per cycle while out_ready_i is high, so bytes that
// give two or three results hold the input off while the queue drains.
// A byte is parsed only while the queue holds at most one result.
// Reset (rst_ni low) returns the parser to waiting for '$' and empties the queue.

module json_path_tokenizer_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [jpt_pkg::CharW-1:0] char_byte_i,
  input  logic                      end_of_query_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [1:0]                event_kind_o,
  output logic [jpt_pkg::CharW-1:0] key_char_o,
  output logic [jpt_pkg::IndexW-1:0] index_value_o,
  output logic [3:0]                status_o,
  output logic                      last_of_run_o
);

  // Input register.
  logic                      in_vld_q;
  logic [jpt_pkg::CharW-1:0] char_q;
  logic                      last_q;

  // Parser state.
  jpt_pkg::mode_e                mode_q, mode_d;
  logic [jpt_pkg::DigitCntW-1:0] cnt_q, cnt_d;
  logic [jpt_pkg::IndexW-1:0]    acc_q, acc_d;
  jpt_pkg::status_e              err_q, err_d;

  // Result queue.
  jpt_pkg::result_t           queue_q [jpt_pkg::QDepth];
  logic [jpt_pkg::QPtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [jpt_pkg::QCntW-1:0]  count_q;

  logic room;
  logic take;
  logic pop;

  // Candidate results of one byte: main event, closing key end, finish.
  logic             a_vld, b_vld, c_vld;
  jpt_pkg::result_t res_a, res_b, res_c;
  logic [jpt_pkg::QPtrW-1:0] pos_a, pos_b, pos_c;
  logic [1:0]                push_n;

  // Segment start decode, shared by two modes.
  jpt_pkg::mode_e   seg_mode;
  logic             seg_fail;
  jpt_pkg::status_e seg_code;

  logic [jpt_pkg::CharW:0]    esc;
  logic [jpt_pkg::IndexW-1:0] acc_next;
  logic [jpt_pkg::IndexW-1:0] digit_val;

  assign room       = (count_q <= jpt_pkg::QCntW'(1));
  assign take       = in_vld_q && room;
  assign in_ready_o = !in_vld_q || room;
  assign pop        = out_valid_o && out_ready_i;

  // Input register load.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      char_q <= char_byte_i;
      last_q <= end_of_query_i;
    end
  end

  // Segment start and helper values.
  always_comb begin
    seg_mode = jpt_pkg::MODE_ERR;
    seg_fail = 1'b1;
    seg_code = jpt_pkg::ST_UNKNOWN_SEG;
    if (last_q) begin
      seg_code = jpt_pkg::ST_DANGLING;
    end else if (char_q == jpt_pkg::ChDot) begin
      seg_mode = jpt_pkg::MODE_DOT_FIRST;
      seg_fail = 1'b0;
    end else if (char_q == jpt_pkg::ChLBracket) begin
      seg_mode = jpt_pkg::MODE_BR_OPEN;
      seg_fail = 1'b0;
    end
  end

  assign esc       = jpt_pkg::decode_escape(char_q);
  assign digit_val = {{(jpt_pkg::IndexW-4){1'b0}}, char_q[3:0]};
  assign acc_next  = (acc_q << 3) + (acc_q << 1) + digit_val;

  // Parser next state and results of the byte in the input register.
  always_comb begin
    mode_d = mode_q;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    err_d  = err_q;
    a_vld  = 1'b0;
    b_vld  = 1'b0;
    c_vld  = 1'b0;
    res_a  = '{kind: jpt_pkg::KIND_KEY_BYTE, key_char: '0, index_value: '0,
               status: jpt_pkg::ST_OK, last_of_run: 1'b0};
    res_b  = '{kind: jpt_pkg::KIND_KEY_END, key_char: '0, index_value: '0,
               status: jpt_pkg::ST_OK, last_of_run: 1'b0};
    res_c  = '{kind: jpt_pkg::KIND_FINISHED, key_char: '0, index_value: '0,
               status: jpt_pkg::ST_OK, last_of_run: 1'b1};

    unique case (mode_q)
      jpt_pkg::MODE_DOLLAR: begin
        if (char_q == jpt_pkg::ChDollar) begin
          mode_d = jpt_pkg::MODE_SEG;
        end else begin
          mode_d = jpt_pkg::MODE_ERR;
          err_d  = jpt_pkg::ST_NO_DOLLAR;
        end
      end
      jpt_pkg::MODE_SEG: begin
        mode_d = seg_mode;
        if (seg_fail) err_d = seg_code;
      end
      jpt_pkg::MODE_DOT_FIRST: begin
        if (jpt_pkg::is_alnum(char_q)) begin
          a_vld          = 1'b1;
          res_a.key_char = char_q;
          mode_d         = jpt_pkg::MODE_DOT_KEY;
        end else begin
          mode_d = jpt_pkg::MODE_ERR;
          err_d  = jpt_pkg::ST_EMPTY_KEY;
        end
      end
      jpt_pkg::MODE_DOT_KEY: begin
        a_vld = 1'b1;
        if (jpt_pkg::is_alnum(char_q)) begin
          res_a.key_char = char_q;
        end else begin
          res_a.kind = jpt_pkg::KIND_KEY_END;
          mode_d     = seg_mode;
          if (seg_fail) err_d = seg_code;
        end
      end
      jpt_pkg::MODE_BR_OPEN: begin
        if (char_q == jpt_pkg::ChQuote) begin
          mode_d = jpt_pkg::MODE_QKEY;
        end else if (char_q == jpt_pkg::ChZero) begin
          mode_d = jpt_pkg::MODE_ZERO_CLOSE;
        end else if ((char_q >= jpt_pkg::ChOne) && (char_q <= jpt_pkg::ChNine)) begin
          acc_d  = digit_val;
          cnt_d  = jpt_pkg::DigitCntW'(1);
          mode_d = jpt_pkg::MODE_DIGITS;
        end else begin
          mode_d = jpt_pkg::MODE_ERR;
          err_d  = jpt_pkg::ST_BAD_BRACKET;
        end
      end
      jpt_pkg::MODE_QKEY: begin
        if (char_q == jpt_pkg::ChBackslash) begin
          mode_d = jpt_pkg::MODE_QESC;
        end else if (char_q == jpt_pkg::ChQuote) begin
          mode_d = jpt_pkg::MODE_QCLOSE;
        end else begin
          a_vld          = 1'b1;
          res_a.key_char = char_q;
        end
      end
      jpt_pkg::MODE_QESC: begin
        if (esc[jpt_pkg::CharW]) begin
          a_vld          = 1'b1;
          res_a.key_char = esc[jpt_pkg::CharW-1:0];
          mode_d         = jpt_pkg::MODE_QKEY;
        end else begin
          mode_d = jpt_pkg::MODE_ERR;
          err_d  = jpt_pkg::ST_BAD_ESCAPE;
        end
      end
      jpt_pkg::MODE_QCLOSE: begin
        if (char_q == jpt_pkg::ChRBracket) begin
          a_vld      = 1'b1;
          res_a.kind = jpt_pkg::KIND_KEY_END;
          mode_d     = jpt_pkg::MODE_SEG;
        end else begin
          mode_d = jpt_pkg::MODE_ERR;
          err_d  = jpt_pkg::ST_MISSING;
        end
      end
      jpt_pkg::MODE_ZERO_CLOSE: begin
        if (char_q == jpt_pkg::ChRBracket) begin
          a_vld      = 1'b1;
          res_a.kind = jpt_pkg::KIND_INDEX;
          mode_d     = jpt_pkg::MODE_SEG;
        end else begin
          mode_d = jpt_pkg::MODE_ERR;
          err_d  = jpt_pkg::ST_MISSING;
        end
      end
      jpt_pkg::MODE_DIGITS: begin
        if (jpt_pkg::is_digit(char_q)) begin
          if (cnt_q < jpt_pkg::MaxDigits) begin
            acc_d = acc_next;
            cnt_d = cnt_q + jpt_pkg::DigitCntW'(1);
          end else begin
            cnt_d = jpt_pkg::MaxDigits + jpt_pkg::DigitCntW'(1);
          end
        end else if (cnt_q > jpt_pkg::MaxDigits) begin
          mode_d = jpt_pkg::MODE_ERR;
          err_d  = jpt_pkg::ST_INDEX_LONG;
        end else if (char_q != jpt_pkg::ChRBracket) begin
          mode_d = jpt_pkg::MODE_ERR;
          err_d  = jpt_pkg::ST_MISSING;
        end else begin
          a_vld             = 1'b1;
          res_a.kind        = jpt_pkg::KIND_INDEX;
          res_a.index_value = acc_q;
          acc_d             = '0;
          cnt_d             = '0;
          mode_d            = jpt_pkg::MODE_SEG;
        end
      end
      jpt_pkg::MODE_ERR: begin
        // Swallow bytes until the end of the query.
      end
      default: begin
        mode_d = jpt_pkg::MODE_ERR;
      end
    endcase

    // Final byte: close an open dot key, report status, return to reset state.
    if (last_q) begin
      c_vld = 1'b1;
      if (err_d != jpt_pkg::ST_OK) begin
        res_c.status = err_d;
      end else if (mode_d == jpt_pkg::MODE_SEG) begin
        res_c.status = jpt_pkg::ST_OK;
      end else if (mode_d == jpt_pkg::MODE_DOT_KEY) begin
        b_vld        = 1'b1;
        res_c.status = jpt_pkg::ST_OK;
      end else if (mode_d == jpt_pkg::MODE_DIGITS) begin
        res_c.status = (cnt_d > jpt_pkg::MaxDigits) ? jpt_pkg::ST_INDEX_LONG
                                                    : jpt_pkg::ST_MISSING;
      end else if ((mode_d == jpt_pkg::MODE_QKEY) || (mode_d == jpt_pkg::MODE_QESC) ||
                   (mode_d == jpt_pkg::MODE_QCLOSE) ||
                   (mode_d == jpt_pkg::MODE_ZERO_CLOSE)) begin
        res_c.status = jpt_pkg::ST_MISSING;
      end else begin
        res_c.status = jpt_pkg::ST_DANGLING;
      end
      mode_d = jpt_pkg::MODE_DOLLAR;
      cnt_d  = '0;
      acc_d  = '0;
      err_d  = jpt_pkg::ST_OK;
    end

    // Mark the final result of this byte.
    res_a.last_of_run = !b_vld && !c_vld;
    res_b.last_of_run = !c_vld;
  end

  // Parser state register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= jpt_pkg::MODE_DOLLAR;
      cnt_q  <= '0;
      acc_q  <= '0;
      err_q  <= jpt_pkg::ST_OK;
    end else if (take) begin
      mode_q <= mode_d;
      cnt_q  <= cnt_d;
      acc_q  <= acc_d;
      err_q  <= err_d;
    end
  end

  // Queue slots for the results of one byte, packed in order.
  assign pos_a  = wr_ptr_q;
  assign pos_b  = wr_ptr_q + jpt_pkg::QPtrW'(a_vld);
  assign pos_c  = pos_b + jpt_pkg::QPtrW'(b_vld);
  assign push_n = 2'(a_vld) + 2'(b_vld) + 2'(c_vld);

  always_ff @(posedge clk_i) begin
    if (take) begin
      if (a_vld) queue_q[pos_a] <= res_a;
      if (b_vld) queue_q[pos_b] <= res_b;
      if (c_vld) queue_q[pos_c] <= res_c;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (take) wr_ptr_q <= wr_ptr_q + jpt_pkg::QPtrW'(push_n);
      if (pop) rd_ptr_q <= rd_ptr_q + jpt_pkg::QPtrW'(1);
      count_q <= count_q + (take ? jpt_pkg::QCntW'(push_n) : '0)
                         - jpt_pkg::QCntW'(pop);
    end
  end

  // Output transaction from the queue head.
  assign out_valid_o   = (count_q != '0);
  assign event_kind_o  = queue_q[rd_ptr_q].kind;
  assign key_char_o    = queue_q[rd_ptr_q].key_char;
  assign index_value_o = queue_q[rd_ptr_q].index_value;
  assign status_o      = queue_q[rd_ptr_q].status;
  assign last_of_run_o = queue_q[rd_ptr_q].last_of_run;

endmodule

// ===== hw/rtl/jpt_checker.sv =====
// ----------------------------------------------------------------------------
// jpt_checker
// Port-level checks on the result stream of the JSONPath tokenizer.
// ----------------------------------------------------------------------------
module jpt_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic [1:0]                 event_kind_o,
  input logic [jpt_pkg::CharW-1:0]  key_char_o,
  input logic [jpt_pkg::IndexW-1:0] index_value_o,
  input logic [3:0]                 status_o,
  input logic                       last_of_run_o
);

  // A stalled result transaction keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(event_kind_o) &&
      $stable(key_char_o) && $stable(index_value_o) && $stable(status_o) &&
      $stable(last_of_run_o))
    else $error("result changed while stalled");

  // The finish result always closes the results of its byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (event_kind_o == jpt_pkg::KIND_FINISHED) |-> last_of_run_o)
    else $error("finish result not marked last");

  // Only a finish result carries a status.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (event_kind_o != jpt_pkg::KIND_FINISHED) |->
      status_o == jpt_pkg::ST_OK)
    else $error("status on a non-finish result");

  // Index values stay within the digit limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> index_value_o <= 34'd9999999999)
    else $error("index value out of range");

endmodule

bind json_path_tokenizer_core jpt_checker u_jpt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .event_kind_o  (event_kind_o),
  .key_char_o    (key_char_o),
  .index_value_o (index_value_o),
  .status_o      (status_o),
  .last_of_run_o (last_of_run_o)
);
